[design/pms_pkg.sv]
// Shared types and constants of the periodic message scheduler.
package pms_pkg;

  localparam int unsigned MaxEntriesDefault = 16;
  localparam int unsigned WalkLimit         = 16;
  localparam int unsigned AddrW             = 3;
  localparam int unsigned IdW               = 16;
  localparam int unsigned RateW             = 16;
  localparam int unsigned CountW            = 16;
  localparam int unsigned IndexW            = 4;
  localparam int unsigned ActiveW           = 5;

  localparam logic [AddrW-1:0] RegActiveEntries = 3'd0;

  localparam logic ActTick = 1'b0;
  localparam logic ActLoad = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [RateW-1:0]  rate;
    logic [CountW-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [IdW-1:0]    message_id;
    logic [IndexW-1:0] entry;
    logic              last;
  } result_t;

endpackage

[design/periodic_message_scheduler_unit.sv]
// Top level of the periodic message scheduler with its configuration register.
//
// A load item (action 1) writes one schedule table entry, if entry_index_i is
// below MAX_ENTRIES, and produces no result; busy stays low. A tick item
// (action 0) walks entries 0 to N-1, where N is active_entries limited to
// sixteen and to MAX_ENTRIES, reading one entry per cycle through the table's
// single read port and writing its updated count back; busy is high while the
// walk runs, and a tick with N of zero does not raise it. Each entry that fires
// yields one result transfer on sent_message_id_o, fired_entry_o and last_o,
// marked by result_valid_o for exactly one cycle; the receiver cannot stall, so
// every strobed cycle is a transfer. last_o marks the final result of a tick; a
// tick in which nothing fires gives no transfer at all. Each hit is held back
// until the next hit or the end of the walk is known, so the last result appears
// in the first cycle with busy low. Table entries are undefined until loaded, and
// a tick must not walk an entry that was never loaded. active_entries sits at
// byte address 0 of the APB port; the user must write it only while idle, as the
// block itself does not enforce this.
module periodic_message_scheduler_unit #(
  parameter int unsigned MAX_ENTRIES = pms_pkg::MaxEntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pms_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [pms_pkg::IndexW-1:0]    entry_index_i,
  input  logic [pms_pkg::IdW-1:0]       message_id_i,
  input  logic [pms_pkg::RateW-1:0]     packet_rate_i,
  input  logic [pms_pkg::CountW-1:0]    start_count_i,
  output logic                          result_valid_o,
  output logic [pms_pkg::IdW-1:0]       sent_message_id_o,
  output logic [pms_pkg::IndexW-1:0]    fired_entry_o,
  output logic                          last_o
);
  import pms_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [ActiveW-1:0] active_entries_q;
  logic               cfg_wr;

  logic               tbl_we;
  logic [AW-1:0]      tbl_waddr;
  entry_t             tbl_wdata;
  logic               tbl_re;
  logic [AW-1:0]      tbl_raddr;
  entry_t             tbl_rdata;
  result_t            res;

  // Configuration: a write transfer completes in the APB access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_entries_q <= '0;
    end else if (cfg_wr && paddr == RegActiveEntries) begin
      active_entries_q <= pwdata[ActiveW-1:0];
    end
  end

  assign prdata = (paddr == RegActiveEntries) ? 32'(active_entries_q) : '0;

  pms_table #(
    .Depth (MAX_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  pms_walker #(
    .MaxEntries (MAX_ENTRIES),
    .AW         (AW)
  ) u_walker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .entry_index_i    (entry_index_i),
    .message_id_i     (message_id_i),
    .packet_rate_i    (packet_rate_i),
    .start_count_i    (start_count_i),
    .active_entries_i (active_entries_q),
    .tbl_we_o         (tbl_we),
    .tbl_waddr_o      (tbl_waddr),
    .tbl_wdata_o      (tbl_wdata),
    .tbl_re_o         (tbl_re),
    .tbl_raddr_o      (tbl_raddr),
    .tbl_rdata_i      (tbl_rdata),
    .res_valid_o      (result_valid_o),
    .res_o            (res)
  );

  assign sent_message_id_o = res.message_id;
  assign fired_entry_o     = res.entry;
  assign last_o            = res.last;

endmodule

[design/pms_table.sv]
// Schedule table memory: one write port, one read port with registered read data.
module pms_table #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AW    = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  pms_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output pms_pkg::entry_t rdata_o
);
  import pms_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/pms_walker.sv]
// Tick walk sequencer: reads, updates and writes back table entries and forms results.
module pms_walker #(
  parameter int unsigned MaxEntries = pms_pkg::MaxEntriesDefault,
  parameter int unsigned AW         = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           action_i,
  input  logic [pms_pkg::IndexW-1:0]     entry_index_i,
  input  logic [pms_pkg::IdW-1:0]        message_id_i,
  input  logic [pms_pkg::RateW-1:0]      packet_rate_i,
  input  logic [pms_pkg::CountW-1:0]     start_count_i,
  input  logic [pms_pkg::ActiveW-1:0]    active_entries_i,
  output logic                           tbl_we_o,
  output logic [AW-1:0]                  tbl_waddr_o,
  output pms_pkg::entry_t                tbl_wdata_o,
  output logic                           tbl_re_o,
  output logic [AW-1:0]                  tbl_raddr_o,
  input  pms_pkg::entry_t                tbl_rdata_i,
  output logic                           res_valid_o,
  output pms_pkg::result_t               res_o
);
  import pms_pkg::*;

  localparam int unsigned LimInt = (MaxEntries < WalkLimit) ? MaxEntries : WalkLimit;
  localparam logic [ActiveW-1:0] Lim = ActiveW'(LimInt);

  logic               busy_q, busy_d;
  logic [ActiveW-1:0] walk_q, walk_d;
  logic [ActiveW-1:0] issue_q, issue_d;
  logic               s1_valid_q, s1_valid_d;
  logic [IndexW-1:0]  s1_idx_q, s1_idx_d;
  logic               done_q, done_d;
  logic               pend_valid_q, pend_valid_d;
  result_t            pend_q, pend_d;
  logic               res_valid_q, res_valid_d;
  result_t            res_q, res_d;

  logic               accept;
  logic [ActiveW-1:0] walk_req;
  logic [CountW:0]    next_count;
  logic               fire;

  assign accept   = start && !busy_q;
  assign walk_req = (active_entries_i > Lim) ? Lim : active_entries_i;

  // The count is compared one bit wider so that the increment never wraps.
  assign next_count = {1'b0, tbl_rdata_i.count} + {{CountW{1'b0}}, 1'b1};
  assign fire       = next_count >= {1'b0, tbl_rdata_i.rate};

  always_comb begin
    busy_d       = busy_q;
    walk_d       = walk_q;
    issue_d      = issue_q;
    s1_valid_d   = 1'b0;
    s1_idx_d     = s1_idx_q;
    done_d       = 1'b0;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    tbl_we_o     = 1'b0;
    tbl_waddr_o  = AW'(entry_index_i);
    tbl_wdata_o  = '{id: message_id_i, rate: packet_rate_i, count: start_count_i};
    tbl_re_o     = 1'b0;
    tbl_raddr_o  = AW'(issue_q);

    if (accept) begin
      if (action_i == ActLoad) begin
        tbl_we_o = 32'(entry_index_i) < MaxEntries;
      end else if (walk_req != '0) begin
        busy_d      = 1'b1;
        walk_d      = walk_req;
        tbl_re_o    = 1'b1;
        tbl_raddr_o = '0;
        issue_d     = ActiveW'(1);
        s1_valid_d  = 1'b1;
        s1_idx_d    = '0;
      end
    end else if (busy_q) begin
      if (issue_q < walk_q) begin
        tbl_re_o   = 1'b1;
        issue_d    = issue_q + ActiveW'(1);
        s1_valid_d = 1'b1;
        s1_idx_d   = IndexW'(issue_q);
      end
      if (s1_valid_q) begin
        tbl_we_o    = 1'b1;
        tbl_waddr_o = AW'(s1_idx_q);
        tbl_wdata_o = '{id: tbl_rdata_i.id, rate: tbl_rdata_i.rate,
                        count: fire ? '0 : next_count[CountW-1:0]};
        if (fire) begin
          // Hold the newest hit back until it is known whether another follows.
          if (pend_valid_q) begin
            res_valid_d = 1'b1;
            res_d       = pend_q;
          end
          pend_valid_d = 1'b1;
          pend_d       = '{message_id: tbl_rdata_i.id, entry: s1_idx_q, last: 1'b0};
        end
        done_d = (ActiveW'(s1_idx_q) + ActiveW'(1)) == walk_q;
      end
      if (done_q) begin
        busy_d       = 1'b0;
        pend_valid_d = 1'b0;
        if (pend_valid_q) begin
          res_valid_d = 1'b1;
          res_d       = '{message_id: pend_q.message_id, entry: pend_q.entry, last: 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      walk_q       <= '0;
      issue_q      <= '0;
      s1_valid_q   <= 1'b0;
      done_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      walk_q       <= walk_d;
      issue_q      <= issue_d;
      s1_valid_q   <= s1_valid_d;
      done_q       <= done_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= s1_idx_d;
    pend_q   <= pend_d;
    res_q    <= res_d;
  end

  assign busy        = busy_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.last |-> !busy_q)
    else $error("last result seen while the walk is still running");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !s1_valid_q && !pend_valid_q && !done_q)
    else $error("walk pipeline active while idle");

  a_wb_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && tbl_we_o |-> s1_valid_q)
    else $error("table write during walk without an entry in flight");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> issue_q <= walk_q && walk_q <= Lim)
    else $error("read index ran past the walk length");
`endif

endmodule
